FILE: design/eapb_pkg.sv
`timescale 1ns / 1ps

package eapb_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int TIME_W     = 32;
  localparam int AVG_W      = 20;   // Q12.8
  localparam int WEIGHT_W   = 9;    // Q1.8, one is 256
  localparam int ACC_W      = 30;   // Q14.16 threshold / EMA accumulator
  localparam int RATE_W     = 16;
  localparam int INTERVAL_W = 16;
  localparam int REFR_W     = 11;
  localparam int FLOOR_W    = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam int MAC_STEPS  = WEIGHT_W;  // one weight bit per cycle

  localparam int unsigned BPM_SCALE = 60000;  // ms per minute
  localparam int unsigned RATE_MAX  = 65535;

  localparam logic [WEIGHT_W-1:0] Q8_ONE = WEIGHT_W'(256);

  localparam logic [REFR_W-1:0]   REFR_RST    = REFR_W'(200);
  localparam logic [WEIGHT_W-1:0] ALPHA_RST   = WEIGHT_W'(32);
  localparam logic [WEIGHT_W-1:0] SIG_W_RST   = WEIGHT_W'(64);
  localparam logic [WEIGHT_W-1:0] NOISE_W_RST = WEIGHT_W'(192);
  localparam logic [FLOOR_W-1:0]  FLOOR_RST   = FLOOR_W'(50);

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [TIME_W-1:0]   time_ms;
  } in_item_t;

  typedef struct packed {
    logic              peak;
    logic [RATE_W-1:0] beats_per_minute;
  } out_item_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REFRACTORY = 3'd0,
    CFG_ALPHA      = 3'd1,
    CFG_SIG_WEIGHT = 3'd2,
    CFG_NOISE_WT   = 3'd3,
    CFG_FLOOR      = 3'd4
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_THR,
    ST_DECIDE,
    ST_EMA,
    ST_SUM_GO,
    ST_SUM,
    ST_DIV,
    ST_DONE
  } state_t;

  // two weighted products summed: x_a*w_a + x_b*w_b
  typedef struct packed {
    logic                start;
    logic [AVG_W-1:0]    x_a;
    logic [WEIGHT_W-1:0] w_a;
    logic [AVG_W-1:0]    x_b;
    logic [WEIGHT_W-1:0] w_b;
  } mac_req_t;

  typedef struct packed {
    logic             done;
    logic [ACC_W-1:0] acc;
  } mac_rsp_t;

  typedef struct packed {
    logic wr_en;
    logic sum_start;
  } ring_ctrl_t;

  function automatic logic [WEIGHT_W-1:0] clamp_q8(input logic [WEIGHT_W-1:0] w);
    return (w > Q8_ONE) ? Q8_ONE : w;
  endfunction

endpackage

FILE: design/eapb_mac.sv
`timescale 1ns / 1ps

// Bit-serial dual multiply-accumulate, one weight bit per cycle.
module eapb_mac
  import eapb_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  mac_req_t req,
  output mac_rsp_t rsp
);

  localparam int STEP_W = $clog2(MAC_STEPS);

  logic [ACC_W-1:0]    ma, mb, acc;
  logic [WEIGHT_W-1:0] wa, wb;
  logic [STEP_W-1:0]   step;
  logic                busy, done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(MAC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc <= '0;
      ma  <= ACC_W'(req.x_a);
      mb  <= ACC_W'(req.x_b);
      wa  <= req.w_a;
      wb  <= req.w_b;
    end else if (busy) begin
      acc <= acc + (wa[0] ? ma : '0) + (wb[0] ? mb : '0);
      ma  <= ma << 1;
      mb  <= mb << 1;
      wa  <= wa >> 1;
      wb  <= wb >> 1;
    end
  end

  assign rsp.done = done;
  assign rsp.acc  = acc;

endmodule

FILE: design/eapb_ring.sv
`timescale 1ns / 1ps

// RR interval ring with a serial summing pass over the filled entries.
module eapb_ring
  import eapb_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  ring_ctrl_t                           ctrl,
  input  logic [INTERVAL_W-1:0]                wr_data,
  output logic [$clog2(DEPTH+1)-1:0]           count,
  output logic [INTERVAL_W+$clog2(DEPTH)-1:0]  sum,
  output logic                                 sum_done
);

  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = INTERVAL_W + $clog2(DEPTH);

  logic [INTERVAL_W-1:0] mem [DEPTH];
  logic [INTERVAL_W-1:0] rd_data;
  logic [ADDR_W-1:0]     slot, rd_idx;
  logic                  issue, rd_vld, last;

  assign last = (CNT_W'(rd_idx) == count - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[slot] <= wr_data;
    end
    rd_data <= mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot     <= '0;
      count    <= '0;
      issue    <= 1'b0;
      rd_vld   <= 1'b0;
      sum_done <= 1'b0;
    end else begin
      sum_done <= rd_vld && !issue;
      rd_vld   <= issue;
      if (ctrl.wr_en) begin
        slot <= (slot == ADDR_W'(DEPTH - 1)) ? '0 : slot + ADDR_W'(1);
        if (count != CNT_W'(DEPTH)) begin
          count <= count + CNT_W'(1);
        end
      end
      if (ctrl.sum_start) begin
        issue <= 1'b1;
      end else if (issue && last) begin
        issue <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.sum_start) begin
      rd_idx <= '0;
      sum    <= '0;
    end else begin
      if (issue && !last) begin
        rd_idx <= rd_idx + ADDR_W'(1);
      end
      if (rd_vld) begin
        sum <= sum + SUM_W'(rd_data);
      end
    end
  end

endmodule

FILE: design/eapb_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module eapb_div #(
  parameter int NUM_W = 19,
  parameter int DEN_W = 19
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] numer,
  input  logic [DEN_W-1:0] denom,
  output logic             done,
  output logic [NUM_W-1:0] quotient
);

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0]  rem, den;
  logic [DEN_W:0]    shifted, trial;
  logic              ge;
  logic [STEP_W-1:0] step;
  logic              busy;

  assign shifted = {rem, quotient[NUM_W-1]};
  assign ge      = (shifted >= {1'b0, den});
  assign trial   = shifted - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= numer;
      den      <= denom;
      rem      <= '0;
    end else if (busy) begin
      rem      <= ge ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
      quotient <= {quotient[NUM_W-2:0], ge};
    end
  end

endmodule

FILE: design/ecg_adaptive_peak_bpm.sv
`timescale 1ns / 1ps
// Adaptive-threshold R-peak detector with heart-rate estimate, one result per sample.
// A sample in the refractory window takes one serial MAC pass (the EMA update), other samples
//   take two (threshold, then EMA); a peak that updates the rate adds a ring sum over the
//   stored intervals and a serial divide.
// One sample in flight: the next is taken the cycle after the result is loaded.
// Synchronous active-high reset clears the sequencer, config, detector state and out_valid.

module ecg_adaptive_peak_bpm
  import eapb_pkg::*;
#(
  parameter int INTERVAL_DEPTH = 8,
  parameter int TIME_BITS      = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CNT_W = $clog2(INTERVAL_DEPTH + 1);
  localparam int SUM_W = INTERVAL_W + $clog2(INTERVAL_DEPTH);
  localparam int NUM_W = $clog2(BPM_SCALE * INTERVAL_DEPTH + 1);

  // config registers
  logic [REFR_W-1:0]   refr_window;
  logic [WEIGHT_W-1:0] ema_alpha_q8, signal_weight_q8, noise_weight_q8;
  logic [FLOOR_W-1:0]  threshold_floor;

  // detector state
  state_t               state, state_next;
  logic [AVG_W-1:0]     signal_average, noise_average;
  logic [TIME_BITS-1:0] last_peak_time;
  logic                 prior_peak_seen;
  logic [RATE_W-1:0]    rate_estimate;

  // per-item working registers
  logic [SAMPLE_W-1:0]  smp;
  logic [TIME_BITS-1:0] now;
  logic                 peak_r;

  // sub-unit wiring
  mac_req_t             mac_req;
  mac_rsp_t             mac_rsp;
  ring_ctrl_t           ring_ctrl;
  logic [CNT_W-1:0]     ring_count;
  logic [SUM_W-1:0]     ring_sum;
  logic                 sum_done;
  logic                 div_start, div_done;
  logic [NUM_W-1:0]     div_numer, quotient;

  // decode
  logic                 accept, out_load;
  logic [TIME_BITS-1:0] since;
  logic                 in_refr;
  logic [WEIGHT_W-1:0]  alpha_c;
  logic [ACC_W-1:0]     floor_q16, thr;
  logic                 is_peak;
  logic [AVG_W-1:0]     ema_avg, ema_src;
  logic                 ema_mode;
  logic [INTERVAL_W-1:0] rr_sat;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;

  // elapsed time since the last peak, wrapping at TIME_BITS
  assign since   = now - last_peak_time;
  assign in_refr = (since < TIME_BITS'(refr_window));
  assign rr_sat  = (since > TIME_BITS'(RATE_MAX)) ? '1 : since[INTERVAL_W-1:0];

  // threshold in Q14.16 comes out of the first MAC pass; floor applied here
  assign floor_q16 = ACC_W'({threshold_floor, 16'b0});
  assign thr       = (mac_rsp.acc < floor_q16) ? floor_q16 : mac_rsp.acc;
  assign is_peak   = (ACC_W'({smp, 16'b0}) > thr);

  // EMA: (256-a)*avg + a*(sample<<8), then drop the 8 fraction bits of the weight
  assign alpha_c  = clamp_q8(ema_alpha_q8);
  assign ema_mode = (state == ST_DECIDE) || in_refr;
  assign ema_src  = (state == ST_DECIDE && is_peak) ? signal_average : noise_average;
  assign ema_avg  = mac_rsp.acc[AVG_W+7:8];

  always_comb begin
    mac_req.start = (state == ST_CHECK) || (state == ST_DECIDE);
    if (ema_mode) begin
      mac_req.x_a = ema_src;
      mac_req.w_a = Q8_ONE - alpha_c;
      mac_req.x_b = AVG_W'({smp, 8'b0});
      mac_req.w_b = alpha_c;
    end else begin
      mac_req.x_a = signal_average;
      mac_req.w_a = clamp_q8(signal_weight_q8);
      mac_req.x_b = noise_average;
      mac_req.w_b = clamp_q8(noise_weight_q8);
    end
  end

  assign div_numer = NUM_W'(ring_count) * NUM_W'(BPM_SCALE);

  eapb_mac u_mac (
    .clk (clk),
    .rst (rst),
    .req (mac_req),
    .rsp (mac_rsp)
  );

  eapb_ring #(
    .DEPTH (INTERVAL_DEPTH)
  ) u_ring (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ring_ctrl),
    .wr_data  (rr_sat),
    .count    (ring_count),
    .sum      (ring_sum),
    .sum_done (sum_done)
  );

  eapb_div #(
    .NUM_W (NUM_W),
    .DEN_W (SUM_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .numer    (div_numer),
    .denom    (ring_sum),
    .done     (div_done),
    .quotient (quotient)
  );

  // sequencer: next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = ST_CHECK;
      ST_CHECK:  state_next = in_refr ? ST_EMA : ST_THR;
      ST_THR:    if (mac_rsp.done) state_next = ST_DECIDE;
      ST_DECIDE: state_next = ST_EMA;
      ST_EMA: begin
        if (mac_rsp.done) begin
          // a second or later interval makes the rate valid
          if (peak_r && prior_peak_seen && ring_count != '0) begin
            state_next = ST_SUM_GO;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_SUM_GO: state_next = ST_SUM;
      ST_SUM: begin
        if (sum_done) state_next = (ring_sum == '0) ? ST_DONE : ST_DIV;
      end
      ST_DIV:    if (div_done) state_next = ST_DONE;
      ST_DONE:   if (!out_valid || !out_stall) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // sequencer: strobes
  always_comb begin
    in_stall            = (state != ST_IDLE);
    ring_ctrl.wr_en     = (state == ST_EMA) && mac_rsp.done && peak_r && prior_peak_seen;
    ring_ctrl.sum_start = (state == ST_SUM_GO);
    div_start           = (state == ST_SUM) && sum_done && (ring_sum != '0);
    out_load            = (state == ST_DONE) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // config writes and detector state
  always_ff @(posedge clk) begin
    if (rst) begin
      refr_window      <= REFR_RST;
      ema_alpha_q8     <= ALPHA_RST;
      signal_weight_q8 <= SIG_W_RST;
      noise_weight_q8  <= NOISE_W_RST;
      threshold_floor  <= FLOOR_RST;
      signal_average   <= '0;
      noise_average    <= '0;
      last_peak_time   <= '0;
      prior_peak_seen  <= 1'b0;
      rate_estimate    <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_REFRACTORY: refr_window      <= cfg_data[REFR_W-1:0];
          CFG_ALPHA:      ema_alpha_q8     <= cfg_data[WEIGHT_W-1:0];
          CFG_SIG_WEIGHT: signal_weight_q8 <= cfg_data[WEIGHT_W-1:0];
          CFG_NOISE_WT:   noise_weight_q8  <= cfg_data[WEIGHT_W-1:0];
          CFG_FLOOR:      threshold_floor  <= cfg_data[FLOOR_W-1:0];
          default: ;  // unmapped index, dropped
        endcase
      end
      if (state == ST_EMA && mac_rsp.done) begin
        if (peak_r) begin
          signal_average  <= ema_avg;
          last_peak_time  <= now;
          prior_peak_seen <= 1'b1;
        end else begin
          noise_average <= ema_avg;
        end
      end
      // zero interval sum reads as maximum rate
      if (state == ST_SUM && sum_done && ring_sum == '0) begin
        rate_estimate <= '1;
      end
      if (state == ST_DIV && div_done) begin
        rate_estimate <= (quotient > NUM_W'(RATE_MAX)) ? '1 : quotient[RATE_W-1:0];
      end
    end
  end

  // item payload
  always_ff @(posedge clk) begin
    if (accept) begin
      smp <= in_data.sample;
      now <= in_data.time_ms[TIME_BITS-1:0];
    end
    if (state == ST_CHECK) begin
      peak_r <= 1'b0;
    end else if (state == ST_DECIDE) begin
      peak_r <= is_peak;
    end
    if (out_load) begin
      out_data.peak             <= peak_r;
      out_data.beats_per_minute <= rate_estimate;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // the MAC only reports back while the sequencer waits on it
  a_mac_done_waited: assert property (@(posedge clk) disable iff (rst)
    mac_rsp.done |-> (state == ST_THR || state == ST_EMA))
    else $error("MAC finished outside a wait state");

  // rate only moves at the end of a sum or divide
  a_rate_source: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && rate_estimate != $past(rate_estimate)) |->
      ($past(state) == ST_SUM || $past(state) == ST_DIV))
    else $error("rate estimate changed outside the rate update");

  // a reported peak has already moved the peak timestamp to its sample
  a_peak_time: assert property (@(posedge clk) disable iff (rst)
    ($rose(out_valid) && out_data.peak) |-> (last_peak_time == now))
    else $error("peak reported without peak time update");

  // a new result appears only from the final state
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_DONE))
    else $error("output item raised outside the final state");

endmodule
